### rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, constants and segment tables for the charger status decoder.
// ----------------------------------------------------------------------------
package csd_pkg;

  // Segment table lengths
  localparam int unsigned CHG_LEN = 16;
  localparam int unsigned DIS_LEN = 13;

  // Datapath widths
  localparam int unsigned SLOPE_W = 24;  // signed slope, scaled by 10^6
  localparam int unsigned LINE_W  = 38;  // signed slope*mv + 1000*intercept
  localparam int unsigned NUM_W   = 46;  // signed line*gain + rounding bias
  localparam int unsigned QT_W    = 28;  // biased numerator over 2^9
  localparam int unsigned PROD_W  = 56;  // reciprocal product

  localparam logic [12:0] FULL_THR_RESET = 13'd4120;

  // Gain is 200 minus the curve base (75 charging, 83 otherwise)
  localparam logic [6:0] CHG_GAIN = 7'd125;
  localparam logic [6:0] DIS_GAIN = 7'd117;

  // Both roundings fold into floor((num + 500500000) / 10^9)
  localparam logic signed [NUM_W-1:0] ROUND_BIAS = 46'sd500500000;
  localparam logic signed [NUM_W-1:0] FULL_SCALE = 46'sd100000000000;

  // 10^9 = 2^9 * 1953125; reciprocal is floor(2^48 / 1953125)
  localparam int unsigned PCT_SHIFT   = 9;
  localparam int unsigned RECIP_SHIFT = 48;
  localparam logic [20:0] PCT_DIV     = 21'd1953125;
  localparam logic [27:0] PCT_RECIP   = 28'd144115188;

  localparam logic [6:0] LEVEL_FULL = 7'd100;
  localparam logic [6:0] LEVEL_EMPTY = 7'd0;

  // Input current: floor(133*c/10) == (c*54477) >> 12 for 8-bit c
  localparam logic [23:0] IMA_RECIP = 24'd54477;

  typedef enum logic [1:0] {
    CS_DISCHARGING  = 2'd0,
    CS_CHARGING     = 2'd1,
    CS_SRC_VALIDATE = 2'd2,
    CS_DONE         = 2'd3
  } chg_state_e;

  typedef enum logic [1:0] {
    CHG_OFF     = 2'd0,
    CHG_TRICKLE = 2'd1,
    CHG_CC      = 2'd2,
    CHG_DONE    = 2'd3
  } chg_status_e;

  // Decoded fields that ride alongside the level computation
  typedef struct packed {
    chg_state_e    chg_state;
    logic [12:0]   bat_mvolt;
    logic [12:0]   sys_mvolt;
    logic [13:0]   vin_mvolt;
    logic [12:0]   charge_ma;
    logic [11:0]   input_ma;
    logic [2:0]    source_type;
    logic          full_flag;
  } info_t;

  // Selected segment and operand for the level datapath
  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [LINE_W-1:0]  icpt_k;
    logic [12:0]               mv;
    logic                      charging;
  } seg_t;

  // Charging curve: lower-bound thresholds
  localparam logic [12:0] CHG_THR [CHG_LEN] = '{
    13'd3545, 13'd3766, 13'd3804, 13'd3822, 13'd3865, 13'd3907, 13'd3928, 13'd3966,
    13'd3981, 13'd4054, 13'd4107, 13'd4209, 13'd4325, 13'd4340, 13'd4345, 13'd4347
  };

  localparam logic signed [SLOPE_W-1:0] CHG_SLOPE [CHG_LEN] = '{
    24'sd0,       24'sd125873,  24'sd3610806, 24'sd1864111,
    24'sd3249592, 24'sd4376704, 24'sd2723910, 24'sd2140409,
    24'sd1197510, 24'sd1441182, 24'sd1255132, 24'sd1073036,
    24'sd1932818, 24'sd4824315, 24'sd7921407, 24'sd386755
  };

  // Intercepts already multiplied by 1000
  localparam logic signed [LINE_W-1:0] CHG_ICPT_K [CHG_LEN] = '{
    38'sd0,             -38'sd473989000,   -38'sd13729670000, -38'sd7053337000,
    -38'sd12408002000, -38'sd16811445000, -38'sd10320033000, -38'sd8005860000,
    -38'sd4252494000,  -38'sd5240413000,  -38'sd4476263000,  -38'sd3709823000,
    -38'sd7428214000,  -38'sd19977425000, -38'sd33434048000, -38'sd681853000
  };

  // Discharging curve: upper-bound thresholds
  localparam logic [12:0] DIS_THR [DIS_LEN] = '{
    13'd3666, 13'd3684, 13'd3690, 13'd3693, 13'd3739, 13'd3783, 13'd3811,
    13'd3848, 13'd3863, 13'd3919, 13'd4091, 13'd4287, 13'd4295
  };

  localparam logic signed [SLOPE_W-1:0] DIS_SLOPE [DIS_LEN] = '{
    24'sd0,       24'sd1067181, 24'sd5094007, 24'sd7839416, 24'sd1713558,
    24'sd2943625, 24'sd3711445, 24'sd2618301, 24'sd2244718, 24'sd1155642,
    24'sd1259872, 24'sd1039723, 24'sd112280
  };

  localparam logic signed [LINE_W-1:0] DIS_ICPT_K [DIS_LEN] = '{
    38'sd0,             -38'sd3912718000,  -38'sd18748272000, -38'sd28878401000,
    -38'sd6256995000,  -38'sd10855810000, -38'sd13760778000, -38'sd9595303000,
    -38'sd8157812000,  -38'sd3950404000,  -38'sd4358917000,  -38'sd3458326000,
    38'sd517724000
  };

endpackage

### rtl/csd_snap_if.sv
// ----------------------------------------------------------------------------
// csd_snap_if
// Valid/ready channel carrying one charger status snapshot.
// ----------------------------------------------------------------------------
interface csd_snap_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [7:0] battery_code;
  logic [7:0] system_code;
  logic [7:0] input_volt_code;
  logic [7:0] charge_amp_code;
  logic [7:0] input_amp_code;

  modport source (
    output valid, status_byte, battery_code, system_code,
           input_volt_code, charge_amp_code, input_amp_code,
    input  ready
  );

  modport sink (
    input  valid, status_byte, battery_code, system_code,
           input_volt_code, charge_amp_code, input_amp_code,
    output ready
  );
endinterface

### rtl/csd_rslt_if.sv
// ----------------------------------------------------------------------------
// csd_rslt_if
// Valid/ready channel carrying one decoded status result.
// ----------------------------------------------------------------------------
interface csd_rslt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  chg_state;
  logic [12:0] bat_mvolt;
  logic [12:0] sys_mvolt;
  logic [13:0] vin_mvolt;
  logic [12:0] charge_ma;
  logic [11:0] input_ma;
  logic [6:0]  soc_pct;
  logic [2:0]  source_type;
  logic        full_flag;

  modport source (
    output valid, chg_state, bat_mvolt, sys_mvolt, vin_mvolt,
           charge_ma, input_ma, soc_pct, source_type, full_flag,
    input  ready
  );

  modport sink (
    input  valid, chg_state, bat_mvolt, sys_mvolt, vin_mvolt,
           charge_ma, input_ma, soc_pct, source_type, full_flag,
    output ready
  );
endinterface

### rtl/csd_select.sv
// ----------------------------------------------------------------------------
// csd_select
// Stage 1: decode status, scale ADC codes, pick the curve segment.
// ----------------------------------------------------------------------------
module csd_select #(
  parameter int unsigned CHARGE_SEGMENTS    = 16,
  parameter int unsigned DISCHARGE_SEGMENTS = 13
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [7:0]          status_byte_i,
  input  logic [7:0]          battery_code_i,
  input  logic [7:0]          system_code_i,
  input  logic [7:0]          input_volt_code_i,
  input  logic [7:0]          charge_amp_code_i,
  input  logic [7:0]          input_amp_code_i,
  input  logic [12:0]         full_thr_i,
  output csd_pkg::info_t      info_o,
  output csd_pkg::seg_t       seg_o
);

  localparam int unsigned CHG_N = (CHARGE_SEGMENTS > csd_pkg::CHG_LEN) ?
                                  csd_pkg::CHG_LEN : CHARGE_SEGMENTS;
  localparam int unsigned DIS_N = (DISCHARGE_SEGMENTS > csd_pkg::DIS_LEN) ?
                                  csd_pkg::DIS_LEN :
                                  ((DISCHARGE_SEGMENTS < 1) ? 1 : DISCHARGE_SEGMENTS);
  localparam int unsigned CHG_IW = $clog2(csd_pkg::CHG_LEN);
  localparam int unsigned DIS_IW = $clog2(csd_pkg::DIS_LEN);

  csd_pkg::info_t      info_d, info_q;
  csd_pkg::seg_t       seg_d, seg_q;
  csd_pkg::chg_status_e chg;
  logic [2:0]          vin;
  logic [12:0]         bmv;
  logic [13:0]         cma_x;
  logic [23:0]         ima_x;
  logic                charging;
  logic                full;
  logic [CHG_IW-1:0]   chg_idx;
  logic [DIS_IW-1:0]   dis_idx;
  logic                chg_run;
  logic                dis_hit;

  // Decode status and scale the ADC codes
  always_comb begin
    vin      = status_byte_i[7:5];
    chg      = csd_pkg::chg_status_e'(status_byte_i[4:3]);
    bmv      = 13'({battery_code_i, 4'd0}) + 13'({battery_code_i, 2'd0});
    cma_x    = 14'({charge_amp_code_i, 5'd0}) + 14'({charge_amp_code_i, 1'b0})
               + 14'(charge_amp_code_i);
    ima_x    = 24'(input_amp_code_i) * csd_pkg::IMA_RECIP;
    charging = (chg == csd_pkg::CHG_TRICKLE) || (chg == csd_pkg::CHG_CC);
    full     = (vin != 3'd0) && ((chg == csd_pkg::CHG_DONE) || (bmv >= full_thr_i));

    info_d.source_type = vin;
    info_d.full_flag   = full;
    info_d.bat_mvolt   = bmv;
    info_d.sys_mvolt   = 13'({system_code_i, 4'd0}) + 13'({system_code_i, 2'd0});
    info_d.vin_mvolt   = 14'({input_volt_code_i, 6'd0}) - 14'({input_volt_code_i, 2'd0});
    info_d.charge_ma   = cma_x[13:1];
    info_d.input_ma    = ima_x[23:12];

    case (chg)
      csd_pkg::CHG_TRICKLE,
      csd_pkg::CHG_CC:   info_d.chg_state = csd_pkg::CS_CHARGING;
      csd_pkg::CHG_DONE: info_d.chg_state = csd_pkg::CS_DONE;
      default: begin
        info_d.chg_state = (vin != 3'd0) ? csd_pkg::CS_SRC_VALIDATE :
                                           csd_pkg::CS_DISCHARGING;
      end
    endcase
  end

  // Charging curve: advance while the voltage clears each lower bound
  always_comb begin
    chg_idx = '0;
    chg_run = 1'b1;
    for (int unsigned i = 1; i < csd_pkg::CHG_LEN; i++) begin
      if (i < CHG_N) begin
        if (chg_run && (bmv >= csd_pkg::CHG_THR[i])) begin
          chg_idx = CHG_IW'(i);
        end else begin
          chg_run = 1'b0;
        end
      end
    end
  end

  // Discharging curve: first upper bound at or above the voltage
  always_comb begin
    dis_idx = DIS_IW'(DIS_N - 1);
    dis_hit = 1'b0;
    for (int unsigned i = 0; i < csd_pkg::DIS_LEN; i++) begin
      if ((i < DIS_N) && !dis_hit && (bmv <= csd_pkg::DIS_THR[i])) begin
        dis_idx = DIS_IW'(i);
        dis_hit = 1'b1;
      end
    end
  end

  // Fetch the segment coefficients
  always_comb begin
    seg_d.mv       = bmv;
    seg_d.charging = charging;
    if (charging) begin
      seg_d.slope  = csd_pkg::CHG_SLOPE[chg_idx];
      seg_d.icpt_k = csd_pkg::CHG_ICPT_K[chg_idx];
    end else begin
      seg_d.slope  = csd_pkg::DIS_SLOPE[dis_idx];
      seg_d.icpt_k = csd_pkg::DIS_ICPT_K[dis_idx];
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      info_q <= info_d;
      seg_q  <= seg_d;
    end
  end

  assign info_o = info_q;
  assign seg_o  = seg_q;

endmodule

### rtl/csd_line.sv
// ----------------------------------------------------------------------------
// csd_line
// Stages 2..4: evaluate the segment line, apply the gain and rounding bias.
// ----------------------------------------------------------------------------
module csd_line (
  input  logic                                clk_i,
  input  logic [2:0]                          en_i,
  input  csd_pkg::seg_t                       seg_i,
  output logic signed [csd_pkg::NUM_W-1:0]    num_o
);

  logic signed [csd_pkg::LINE_W-1:0] prod_d, prod_q;
  logic signed [csd_pkg::LINE_W-1:0] icpt_q;
  logic                              chg2_q;
  logic signed [csd_pkg::LINE_W-1:0] line_d, line_q;
  logic [6:0]                        gain_d, gain_q;
  logic signed [csd_pkg::NUM_W-1:0]  num_d, num_q;

  // Stage 2: slope times millivolts
  assign prod_d = seg_i.slope * $signed({1'b0, seg_i.mv});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      icpt_q <= seg_i.icpt_k;
      chg2_q <= seg_i.charging;
    end
  end

  // Stage 3: add the scaled intercept, pick the gain
  assign line_d = prod_q + icpt_q;
  assign gain_d = chg2_q ? csd_pkg::CHG_GAIN : csd_pkg::DIS_GAIN;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      line_q <= line_d;
      gain_q <= gain_d;
    end
  end

  // Stage 4: apply the gain and the combined rounding bias
  assign num_d = (line_q * $signed({1'b0, gain_q})) + csd_pkg::ROUND_BIAS;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      num_q <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

### rtl/csd_div.sv
// ----------------------------------------------------------------------------
// csd_div
// Stages 5..6: divide the biased numerator by 10^9 and clamp to 0..100.
// ----------------------------------------------------------------------------
module csd_div (
  input  logic                              clk_i,
  input  logic [1:0]                        en_i,
  input  logic signed [csd_pkg::NUM_W-1:0]  num_i,
  input  logic                              full_i,
  output logic [6:0]                        level_o
);

  logic [csd_pkg::QT_W-1:0]   quot_in;
  logic [csd_pkg::PROD_W-1:0] recip_d, recip_q;
  logic [csd_pkg::QT_W-1:0]   quot_q;
  logic                       neg_q;
  logic                       big_q;
  logic [7:0]                 q_est;
  logic [csd_pkg::QT_W-1:0]   q_back;
  logic [csd_pkg::QT_W-1:0]   rem;
  logic [7:0]                 q_fix;
  logic [6:0]                 level_d, level_q;

  // Stage 5: drop the power-of-two factor, multiply by the reciprocal
  assign quot_in = num_i[csd_pkg::PCT_SHIFT +: csd_pkg::QT_W];
  assign recip_d = csd_pkg::PROD_W'(quot_in) * csd_pkg::PROD_W'(csd_pkg::PCT_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      recip_q <= recip_d;
      quot_q  <= quot_in;
      neg_q   <= num_i[csd_pkg::NUM_W-1];
      big_q   <= (num_i >= csd_pkg::FULL_SCALE);
    end
  end

  // Stage 6: correct the estimate by at most one, then clamp
  always_comb begin
    q_est  = recip_q[csd_pkg::RECIP_SHIFT +: 8];
    q_back = csd_pkg::QT_W'(29'(q_est) * 29'(csd_pkg::PCT_DIV));
    rem    = quot_q - q_back;
    q_fix  = q_est + 8'(rem >= csd_pkg::QT_W'(csd_pkg::PCT_DIV));
    if (full_i || big_q) begin
      level_d = csd_pkg::LEVEL_FULL;
    end else if (neg_q) begin
      level_d = csd_pkg::LEVEL_EMPTY;
    end else begin
      level_d = q_fix[6:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

### rtl/charger_status_decode_soc_unit.sv
// ----------------------------------------------------------------------------
// charger_status_decode_soc_unit
// Charger status decoder with a piecewise-linear state-of-charge estimate.
// ----------------------------------------------------------------------------
// One snapshot (status byte and five ADC codes) is taken per transaction and
// one result comes out for each, in order. The block accepts a transaction
// every cycle while the result channel is not stalled; each result passes
// through six register stages (segment select, slope multiply, intercept
// add, gain multiply, reciprocal multiply, correction and clamp). Each stage
// holds only while its successor is full and stalled, so empty stages fill
// even when the output is held. The full threshold register may be written
// at any time the pipeline is empty; it resets to 4120 mV.
module charger_status_decode_soc_unit #(
  parameter int unsigned CHARGE_SEGMENTS    = 16,
  parameter int unsigned DISCHARGE_SEGMENTS = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  csd_snap_if.sink          snap_i,
  csd_rslt_if.source        rslt_o,
  input  logic              cfg_we_i,
  input  logic [12:0]       cfg_wdata_i
);

  localparam int unsigned NSTG = 6;

  logic [12:0]                      full_thr_q;
  logic [NSTG-1:0]                  vld_q;
  logic [NSTG-1:0]                  en;
  csd_pkg::info_t                   info_s1;
  csd_pkg::info_t                   info_q [NSTG-1];
  csd_pkg::seg_t                    seg_s1;
  logic signed [csd_pkg::NUM_W-1:0] num_s4;
  logic [6:0]                       level_s6;

  // Hold the full threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_thr_q <= csd_pkg::FULL_THR_RESET;
    end else if (cfg_we_i) begin
      full_thr_q <= cfg_wdata_i;
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || rslt_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign snap_i.ready = en[0];

  // Move valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= snap_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  csd_select #(
    .CHARGE_SEGMENTS    (CHARGE_SEGMENTS),
    .DISCHARGE_SEGMENTS (DISCHARGE_SEGMENTS)
  ) u_select (
    .clk_i             (clk_i),
    .en_i              (en[0]),
    .status_byte_i     (snap_i.status_byte),
    .battery_code_i    (snap_i.battery_code),
    .system_code_i     (snap_i.system_code),
    .input_volt_code_i (snap_i.input_volt_code),
    .charge_amp_code_i (snap_i.charge_amp_code),
    .input_amp_code_i  (snap_i.input_amp_code),
    .full_thr_i        (full_thr_q),
    .info_o            (info_s1),
    .seg_o             (seg_s1)
  );

  csd_line u_line (
    .clk_i (clk_i),
    .en_i  (en[3:1]),
    .seg_i (seg_s1),
    .num_o (num_s4)
  );

  csd_div u_div (
    .clk_i   (clk_i),
    .en_i    (en[5:4]),
    .num_i   (num_s4),
    .full_i  (info_q[NSTG-3].full_flag),
    .level_o (level_s6)
  );

  // Carry the decoded fields down stages 2..6
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      info_q[0] <= info_s1;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en[k+1]) begin
        info_q[k] <= info_q[k-1];
      end
    end
  end

  // Drive the result channel from the last stage
  assign rslt_o.valid       = vld_q[NSTG-1];
  assign rslt_o.chg_state   = info_q[NSTG-2].chg_state;
  assign rslt_o.bat_mvolt   = info_q[NSTG-2].bat_mvolt;
  assign rslt_o.sys_mvolt   = info_q[NSTG-2].sys_mvolt;
  assign rslt_o.vin_mvolt   = info_q[NSTG-2].vin_mvolt;
  assign rslt_o.charge_ma   = info_q[NSTG-2].charge_ma;
  assign rslt_o.input_ma    = info_q[NSTG-2].input_ma;
  assign rslt_o.soc_pct     = level_s6;
  assign rslt_o.source_type = info_q[NSTG-2].source_type;
  assign rslt_o.full_flag   = info_q[NSTG-2].full_flag;

  // Checks
  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rslt_o.valid && rslt_o.full_flag |-> rslt_o.soc_pct == csd_pkg::LEVEL_FULL)
    else $error("full result without a full level");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rslt_o.valid |-> rslt_o.soc_pct <= csd_pkg::LEVEL_FULL)
    else $error("level above full scale");

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rslt_o.valid && (rslt_o.source_type != 3'd0) &&
    (rslt_o.chg_state == csd_pkg::CS_DONE) |-> rslt_o.full_flag)
    else $error("charge done with a source but not flagged full");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_i.valid && snap_i.ready |=> vld_q[0])
    else $error("accepted transaction did not enter stage 1");

endmodule

### bench/status_decode_checker.sv
// ----------------------------------------------------------------------------
// status_decode_checker
// Watches the snapshot and result channels of the charger status decoder,
// works out the expected decode and charge level for each accepted snapshot,
// and compares each result with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module status_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  csd_snap_if         snap,
  csd_rslt_if         rslt,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    csd_pkg::chg_state_e chg_state;
    logic [12:0]   bat_mvolt;
    logic [12:0]   sys_mvolt;
    logic [13:0]   vin_mvolt;
    logic [12:0]   charge_ma;
    logic [11:0]   input_ma;
    logic [6:0]    soc_pct;
    logic [2:0]    source_type;
    logic          full_flag;
  } decoded_status_t;

  // Charging curve: knee voltages (lower bounds), slopes and intercepts x10^6
  localparam longint CHG_KNEE_MV [16] = '{
    3545, 3766, 3804, 3822, 3865, 3907, 3928, 3966,
    3981, 4054, 4107, 4209, 4325, 4340, 4345, 4347
  };
  localparam longint CHG_SLOPE_U [16] = '{
    0, 125873, 3610806, 1864111, 3249592, 4376704, 2723910, 2140409,
    1197510, 1441182, 1255132, 1073036, 1932818, 4824315, 7921407, 386755
  };
  localparam longint CHG_OFFSET_U [16] = '{
    0, -473989, -13729670, -7053337, -12408002, -16811445, -10320033, -8005860,
    -4252494, -5240413, -4476263, -3709823, -7428214, -19977425, -33434048, -681853
  };

  // Discharging curve: knee voltages (upper bounds)
  localparam longint DIS_KNEE_MV [13] = '{
    3666, 3684, 3690, 3693, 3739, 3783, 3811, 3848, 3863, 3919, 4091, 4287, 4295
  };
  localparam longint DIS_SLOPE_U [13] = '{
    0, 1067181, 5094007, 7839416, 1713558, 2943625, 3711445, 2618301,
    2244718, 1155642, 1259872, 1039723, 112280
  };
  localparam longint DIS_OFFSET_U [13] = '{
    0, -3912718, -18748272, -28878401, -6256995, -10855810, -13760778, -9595303,
    -8157812, -3950404, -4358917, -3458326, 517724
  };

  localparam longint GAIN_CHARGING    = 200 - 75;
  localparam longint GAIN_DISCHARGING = 200 - 83;
  localparam longint MICRO            = 1000000;

  logic [12:0]     full_thr_mv = 13'd4120;
  decoded_status_t expected_results [$];
  int unsigned     mismatches = 0;

  assign fail_count = mismatches;

  // Evaluate one line segment and round to whole percent
  function automatic logic [6:0] segment_level(input longint slope, input longint offset,
                                               input longint gain, input longint mv);
    longint line_val;
    longint num;
    longint milli_pct;
    line_val = slope * mv + offset * 1000;
    num      = line_val * gain;
    if (num < 0)
      milli_pct = (num - MICRO / 2) / MICRO;
    else
      milli_pct = (num + MICRO / 2) / MICRO;
    if (milli_pct <= 0)
      return 7'd0;
    if (milli_pct >= 100000)
      return 7'd100;
    return 7'((milli_pct + 500) / 1000);
  endfunction

  // Charging: advance through segments while the voltage reaches their knee
  function automatic logic [6:0] charging_level(input longint mv);
    int pick;
    pick = 0;
    for (int i = 1; i < 16; i++) begin
      if (mv < CHG_KNEE_MV[i])
        break;
      pick = i;
    end
    return segment_level(CHG_SLOPE_U[pick], CHG_OFFSET_U[pick], GAIN_CHARGING, mv);
  endfunction

  // Discharging: first segment whose knee is not below the voltage, else the last
  function automatic logic [6:0] discharging_level(input longint mv);
    for (int i = 0; i < 13; i++) begin
      if (mv <= DIS_KNEE_MV[i])
        return segment_level(DIS_SLOPE_U[i], DIS_OFFSET_U[i], GAIN_DISCHARGING, mv);
    end
    return segment_level(DIS_SLOPE_U[12], DIS_OFFSET_U[12], GAIN_DISCHARGING, mv);
  endfunction

  function automatic decoded_status_t predict_status(
    input logic [7:0] status, input logic [7:0] bat_code, input logic [7:0] sys_code,
    input logic [7:0] vin_code, input logic [7:0] chg_amp, input logic [7:0] in_amp,
    input logic [12:0] thr_mv);
    decoded_status_t      d;
    csd_pkg::chg_status_e cs;
    int unsigned          bat_mv;
    logic                 charging;
    cs       = csd_pkg::chg_status_e'(status[4:3]);
    charging = (cs == csd_pkg::CHG_TRICKLE) || (cs == csd_pkg::CHG_CC);
    bat_mv   = 20 * bat_code;

    d.source_type = status[7:5];
    d.bat_mvolt   = 13'(bat_mv);
    d.sys_mvolt   = 13'(20 * sys_code);
    d.vin_mvolt   = 14'(60 * vin_code);
    d.charge_ma   = 13'((17500 * chg_amp) / 1000);
    d.input_ma    = 12'((13300 * in_amp) / 1000);

    if (charging)
      d.chg_state = csd_pkg::CS_CHARGING;
    else if (cs == csd_pkg::CHG_DONE)
      d.chg_state = csd_pkg::CS_DONE;
    else if (d.source_type != 3'd0)
      d.chg_state = csd_pkg::CS_SRC_VALIDATE;
    else
      d.chg_state = csd_pkg::CS_DISCHARGING;

    d.full_flag = (d.source_type != 3'd0) && (cs == csd_pkg::CHG_DONE || bat_mv >= thr_mv);

    if (d.full_flag)
      d.soc_pct = 7'd100;
    else if (charging)
      d.soc_pct = charging_level(longint'(bat_mv));
    else
      d.soc_pct = discharging_level(longint'(bat_mv));
    return d;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Predict on each accepted snapshot, compare on each accepted result
  always @(posedge clk_i) begin
    decoded_status_t want;
    if (rst_ni) begin
      if (snap.valid && snap.ready)
        expected_results.push_back(predict_status(snap.status_byte, snap.battery_code,
          snap.system_code, snap.input_volt_code, snap.charge_amp_code,
          snap.input_amp_code, full_thr_mv));

      if (rslt.valid && rslt.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, outstanding count", 0, 1);
        end else begin
          want = expected_results.pop_front();
          if (rslt.chg_state != want.chg_state)
            report_mismatch("chg_state", rslt.chg_state, want.chg_state);
          if (rslt.bat_mvolt != want.bat_mvolt)
            report_mismatch("bat_mvolt", rslt.bat_mvolt, want.bat_mvolt);
          if (rslt.sys_mvolt != want.sys_mvolt)
            report_mismatch("sys_mvolt", rslt.sys_mvolt, want.sys_mvolt);
          if (rslt.vin_mvolt != want.vin_mvolt)
            report_mismatch("vin_mvolt", rslt.vin_mvolt, want.vin_mvolt);
          if (rslt.charge_ma != want.charge_ma)
            report_mismatch("charge_ma", rslt.charge_ma, want.charge_ma);
          if (rslt.input_ma != want.input_ma)
            report_mismatch("input_ma", rslt.input_ma, want.input_ma);
          if (rslt.soc_pct != want.soc_pct)
            report_mismatch("soc_pct", rslt.soc_pct, want.soc_pct);
          if (rslt.source_type != want.source_type)
            report_mismatch("source_type", rslt.source_type, want.source_type);
          if (rslt.full_flag != want.full_flag)
            report_mismatch("full_flag", rslt.full_flag, want.full_flag);
        end
      end

      // Track the full threshold as the block sees it
      if (cfg_we_i)
        full_thr_mv = cfg_wdata_i;
    end else begin
      full_thr_mv = csd_pkg::FULL_THR_RESET;
    end
    pending = expected_results.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the charger status decoder. Runs directed
// snapshots around the curve knees and the full-flag cases, then phases of
// random snapshots under several full thresholds, with random stalls on both
// channels, one long output hold and one drained pause.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = 13'd0;
  int unsigned fail_count;
  int unsigned pending;

  logic        idling_on = 1'b1;
  logic        long_hold_req = 1'b0;
  int unsigned hold_len;

  logic [7:0]  chg_codes [9] = '{8'd177, 8'd188, 8'd190, 8'd191, 8'd196,
                                 8'd199, 8'd205, 8'd217, 8'd218};
  logic [7:0]  dis_codes [5] = '{8'd183, 8'd184, 8'd185, 8'd215, 8'd216};
  logic [12:0] phase_thr [7];

  csd_snap_if snap_ch ();
  csd_rslt_if rslt_ch ();

  charger_status_decode_soc_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_i      (snap_ch),
    .rslt_o      (rslt_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  status_decode_checker decode_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap        (snap_ch),
    .rslt        (rslt_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always #2 clk_i = ~clk_i;

  // Hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Drive the result ready: random stall bursts, and one long hold on request
  initial begin
    rslt_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rslt_ch.ready = 1'b0;
        repeat (99) @(negedge clk_i);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        hold_len = $urandom_range(1, 14);
        rslt_ch.ready = 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
      end else begin
        rslt_ch.ready = 1'b1;
      end
    end
  end

  // Offer one snapshot and hold it until accepted
  task automatic send_snapshot(input logic [7:0] status, input logic [7:0] bat_code,
                               input logic [7:0] sys_code, input logic [7:0] vin_code,
                               input logic [7:0] chg_amp, input logic [7:0] in_amp);
    @(negedge clk_i);
    snap_ch.valid           = 1'b1;
    snap_ch.status_byte     = status;
    snap_ch.battery_code    = bat_code;
    snap_ch.system_code     = sys_code;
    snap_ch.input_volt_code = vin_code;
    snap_ch.charge_amp_code = chg_amp;
    snap_ch.input_amp_code  = in_amp;
    @(posedge clk_i);
    while (!snap_ch.ready) @(posedge clk_i);
  endtask

  // Random snapshot, battery codes mostly inside the curve range
  task automatic send_random();
    logic [7:0] bat_code;
    if ($urandom_range(0, 9) < 6)
      bat_code = 8'($urandom_range(170, 222));
    else
      bat_code = 8'($urandom_range(0, 255));
    send_snapshot(8'($urandom_range(0, 255)), bat_code, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
  endtask

  task automatic idle_cycles(input int unsigned n);
    @(negedge clk_i);
    snap_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Drop valid, wait until every result is back, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    snap_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [12:0] thr_mv);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = thr_mv;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  initial begin
    snap_ch.valid           = 1'b0;
    snap_ch.status_byte     = 8'd0;
    snap_ch.battery_code    = 8'd0;
    snap_ch.system_code     = 8'd0;
    snap_ch.input_volt_code = 8'd0;
    snap_ch.charge_amp_code = 8'd0;
    snap_ch.input_amp_code  = 8'd0;

    phase_thr[0] = 13'd3400;
    phase_thr[1] = 13'd4670;
    phase_thr[2] = 13'd0;
    phase_thr[3] = 13'h1FFF;
    phase_thr[4] = 13'($urandom_range(3400, 4670));
    phase_thr[5] = 13'($urandom_range(0, 8191));
    phase_thr[6] = 13'd4120;

    // Hold reset, release on a falling edge
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes and full-flag cases at the reset threshold
    send_snapshot(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_snapshot(8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_snapshot(8'h08, 8'd180, 8'd12, 8'd80, 8'd100, 8'd7);
    send_snapshot(8'h18, 8'd150, 8'd150, 8'd1, 8'd1, 8'd1);
    send_snapshot(8'h20, 8'd205, 8'd170, 8'd90, 8'd0, 8'd200);
    send_snapshot(8'h20, 8'd206, 8'd170, 8'd90, 8'd0, 8'd200);
    send_snapshot(8'hE8, 8'd190, 8'd190, 8'd85, 8'd64, 8'd33);
    send_snapshot(8'h07, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);

    // Directed: charging and discharging knees
    foreach (chg_codes[i])
      send_snapshot(8'h10, chg_codes[i], 8'($urandom_range(0, 255)), 8'd100, 8'd40, 8'd20);
    foreach (dis_codes[i])
      send_snapshot(8'h00, dis_codes[i], 8'($urandom_range(0, 255)), 8'd0, 8'd0, 8'd0);

    // Random phases, one threshold each; the last runs without idling
    for (int p = 0; p < 7; p++) begin
      drain();
      write_threshold(phase_thr[p]);
      for (int n = 0; n < 160; n++) begin
        if (n % 40 == 0)
          idling_on = (p != 6) && ($urandom_range(0, 3) != 0);
        if (p == 0 && n == 60)
          long_hold_req = 1'b1;
        if (p == 1 && n == 80)
          drain();
        if (idling_on && $urandom_range(0, 4) == 0)
          idle_cycles($urandom_range(1, 14));
        send_random();
      end
    end

    drain();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/csd_pkg.sv
rtl/csd_snap_if.sv
rtl/csd_rslt_if.sv
rtl/csd_select.sv
rtl/csd_line.sv
rtl/csd_div.sv
rtl/charger_status_decode_soc_unit.sv
bench/status_decode_checker.sv
bench/testbench.sv
